@@ rtl/core/ilr_pkg.sv @@
package ilr_pkg;

  localparam int unsigned OUT_COUNT_WIDTH = 16;

  localparam logic [2:0] ST_START  = 3'd0;
  localparam logic [2:0] ST_LEAD   = 3'd1;
  localparam logic [2:0] ST_ZERO   = 3'd2;
  localparam logic [2:0] ST_DEC    = 3'd3;
  localparam logic [2:0] ST_OCT    = 3'd4;
  localparam logic [2:0] ST_HEX_X  = 3'd5;
  localparam logic [2:0] ST_HEX    = 3'd6;
  localparam logic [2:0] ST_REJECT = 3'd7;

  localparam logic [2:0] CL_SIGN   = 3'd0;
  localparam logic [2:0] CL_ZERO   = 3'd1;
  localparam logic [2:0] CL_X      = 3'd2;
  localparam logic [2:0] CL_SEP    = 3'd3;
  localparam logic [2:0] CL_OCTDIG = 3'd4;
  localparam logic [2:0] CL_DECDIG = 3'd5;
  localparam logic [2:0] CL_HEXDIG = 3'd6;
  localparam logic [2:0] CL_OTHER  = 3'd7;

  // Rows are indexed by the current state, columns by the character class.
  localparam logic [2:0] NEXT_STATE [0:7][0:7] = '{
    '{ST_LEAD,   ST_ZERO,   ST_REJECT, ST_REJECT, ST_LEAD,   ST_LEAD,   ST_REJECT, ST_REJECT},
    '{ST_REJECT, ST_REJECT, ST_REJECT, ST_REJECT, ST_DEC,    ST_DEC,    ST_REJECT, ST_REJECT},
    '{ST_REJECT, ST_OCT,    ST_HEX_X,  ST_START,  ST_OCT,    ST_REJECT, ST_REJECT, ST_REJECT},
    '{ST_REJECT, ST_DEC,    ST_REJECT, ST_START,  ST_DEC,    ST_DEC,    ST_REJECT, ST_REJECT},
    '{ST_REJECT, ST_OCT,    ST_REJECT, ST_START,  ST_OCT,    ST_REJECT, ST_REJECT, ST_REJECT},
    '{ST_REJECT, ST_HEX,    ST_REJECT, ST_REJECT, ST_HEX,    ST_HEX,    ST_HEX,    ST_REJECT},
    '{ST_REJECT, ST_HEX,    ST_REJECT, ST_START,  ST_HEX,    ST_HEX,    ST_HEX,    ST_REJECT},
    '{ST_REJECT, ST_REJECT, ST_REJECT, ST_REJECT, ST_REJECT, ST_REJECT, ST_REJECT, ST_REJECT}
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } ilr_in_t;

  typedef struct packed {
    logic                       accepted;
    logic                       rejected;
    logic [OUT_COUNT_WIDTH-1:0] decimal_count;
    logic [OUT_COUNT_WIDTH-1:0] octal_count;
    logic [OUT_COUNT_WIDTH-1:0] hex_count;
    logic                       word_done;
  } ilr_out_t;

  function automatic logic [2:0] char_class(input logic [7:0] c);
    logic [2:0] cls;
    case (c) inside
      8'h2B, 8'h2D:   cls = CL_SIGN;
      8'h30:          cls = CL_ZERO;
      8'h78:          cls = CL_X;
      8'h23:          cls = CL_SEP;
      [8'h31:8'h37]:  cls = CL_OCTDIG;
      8'h38, 8'h39:   cls = CL_DECDIG;
      [8'h41:8'h46]:  cls = CL_HEXDIG;
      default:        cls = CL_OTHER;
    endcase
    return cls;
  endfunction

endpackage

@@ rtl/core/ilr_step.sv @@
module ilr_step
  import ilr_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  ilr_in_t                item,
  input  logic [2:0]             state,
  input  logic                   armed,
  input  logic [COUNT_WIDTH-1:0] dec_tally,
  input  logic [COUNT_WIDTH-1:0] oct_tally,
  input  logic [COUNT_WIDTH-1:0] hex_tally,
  output logic [2:0]             state_nxt,
  output logic                   armed_nxt,
  output logic [COUNT_WIDTH-1:0] dec_tally_nxt,
  output logic [COUNT_WIDTH-1:0] oct_tally_nxt,
  output logic [COUNT_WIDTH-1:0] hex_tally_nxt,
  output ilr_out_t               result
);

  logic [2:0]             cls;
  logic [2:0]             s;
  logic                   dec_inc;
  logic                   oct_inc;
  logic                   hex_inc;
  logic                   armed_new;
  logic [COUNT_WIDTH-1:0] dec_new;
  logic [COUNT_WIDTH-1:0] oct_new;
  logic [COUNT_WIDTH-1:0] hex_new;

  assign cls = char_class(item.char_code);
  assign s   = NEXT_STATE[state][cls];

  assign dec_inc = armed && (s == ST_LEAD || s == ST_DEC);
  assign oct_inc = armed && (s == ST_ZERO);
  assign hex_inc = armed && (s == ST_HEX_X);

  always_comb begin
    dec_new = dec_tally;
    oct_new = oct_tally;
    hex_new = hex_tally;
    if (dec_inc && !(&dec_tally)) begin
      dec_new = dec_tally + 1'b1;
    end
    if (oct_inc && !(&oct_tally)) begin
      oct_new = oct_tally + 1'b1;
    end
    if (hex_inc) begin
      if (!(&hex_tally)) begin
        hex_new = hex_tally + 1'b1;
      end
      if (oct_tally != '0) begin
        oct_new = oct_tally - 1'b1;
      end
    end
    if (s == ST_START) begin
      armed_new = 1'b1;
    end else if (dec_inc) begin
      armed_new = 1'b0;
    end else begin
      armed_new = armed;
    end
  end

  always_comb begin
    result.accepted      = item.last_char &&
                           (s == ST_ZERO || s == ST_DEC || s == ST_OCT || s == ST_HEX);
    result.rejected      = (s == ST_REJECT);
    result.decimal_count = OUT_COUNT_WIDTH'(dec_new);
    result.octal_count   = OUT_COUNT_WIDTH'(oct_new);
    result.hex_count     = OUT_COUNT_WIDTH'(hex_new);
    result.word_done     = item.last_char;
    if (item.last_char) begin
      state_nxt     = ST_START;
      armed_nxt     = 1'b1;
      dec_tally_nxt = '0;
      oct_tally_nxt = '0;
      hex_tally_nxt = '0;
    end else begin
      state_nxt     = s;
      armed_nxt     = armed_new;
      dec_tally_nxt = dec_new;
      oct_tally_nxt = oct_new;
      hex_tally_nxt = hex_new;
    end
  end

endmodule

@@ rtl/core/integer_literal_list_recognizer.sv @@
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  ilr_in_t  (char_code, last_char)
// out_     output     out_valid/ out_stall ilr_out_t (flags, counts, word_done)
//
// One item per cycle is sustained while the output does not stall; an item is held in the
// input register, and its result is shown from the result register once the item advances.
// The automaton and tallies advance as an item moves from the input register to the
// result register, so the next item always sees the state that its predecessor left.
// Reset is synchronous and active low; it empties both registers and restores the
// start state. A stall on the output holds the result, and the input stalls only
// while both registers are full and the output stalls.
module integer_literal_list_recognizer
  import ilr_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ilr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ilr_out_t out_data
);

  ilr_in_t                in_r;
  logic                   in_valid_r;
  ilr_out_t               out_r;
  logic                   out_valid_r;
  logic [2:0]             state_r;
  logic                   armed_r;
  logic [COUNT_WIDTH-1:0] dec_tally_r;
  logic [COUNT_WIDTH-1:0] oct_tally_r;
  logic [COUNT_WIDTH-1:0] hex_tally_r;

  logic [2:0]             state_nxt;
  logic                   armed_nxt;
  logic [COUNT_WIDTH-1:0] dec_tally_nxt;
  logic [COUNT_WIDTH-1:0] oct_tally_nxt;
  logic [COUNT_WIDTH-1:0] hex_tally_nxt;
  ilr_out_t               result;
  logic                   advance;
  logic                   in_take;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  ilr_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .item          (in_r),
    .state         (state_r),
    .armed         (armed_r),
    .dec_tally     (dec_tally_r),
    .oct_tally     (oct_tally_r),
    .hex_tally     (hex_tally_r),
    .state_nxt     (state_nxt),
    .armed_nxt     (armed_nxt),
    .dec_tally_nxt (dec_tally_nxt),
    .oct_tally_nxt (oct_tally_nxt),
    .hex_tally_nxt (hex_tally_nxt),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ST_START;
      armed_r     <= 1'b1;
      dec_tally_r <= '0;
      oct_tally_r <= '0;
      hex_tally_r <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
        armed_r     <= armed_nxt;
        dec_tally_r <= dec_tally_nxt;
        oct_tally_r <= oct_tally_nxt;
        hex_tally_r <= hex_tally_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/ilr_checker.sv @@
module ilr_checker
  import ilr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input ilr_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input ilr_out_t out_data
);

  // A stalled input item must stay offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");

  // A held result must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A word can only be accepted on its final item.
  a_accept_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.accepted && !out_data.word_done))
    else $error("accept flagged before the end of the word");

  // The reject state is sticky, so a rejected word is never accepted.
  a_accept_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.accepted && out_data.rejected))
    else $error("result both accepted and rejected");

  // No item leaves the block straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind integer_literal_list_recognizer ilr_checker u_ilr_checker (.*);

@@ tb/integer_literal_list_recognizer_tb.sv @@
module integer_literal_list_recognizer_tb
  import ilr_pkg::*;
();

  localparam int QUIET_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 460;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         pinned;
    ilr_out_t   want;
  } stim_row_t;

  typedef struct {
    bit       pinned;
    ilr_out_t want;
  } pin_t;

  // Next state, indexed by current state and then by character class.
  localparam logic [2:0] MOVE [8][8] = '{
    '{3'd1, 3'd2, 3'd7, 3'd7, 3'd1, 3'd1, 3'd7, 3'd7},
    '{3'd7, 3'd7, 3'd7, 3'd7, 3'd3, 3'd3, 3'd7, 3'd7},
    '{3'd7, 3'd4, 3'd5, 3'd0, 3'd4, 3'd7, 3'd7, 3'd7},
    '{3'd7, 3'd3, 3'd7, 3'd0, 3'd3, 3'd3, 3'd7, 3'd7},
    '{3'd7, 3'd4, 3'd7, 3'd0, 3'd4, 3'd7, 3'd7, 3'd7},
    '{3'd7, 3'd6, 3'd7, 3'd7, 3'd6, 3'd6, 3'd6, 3'd7},
    '{3'd7, 3'd6, 3'd7, 3'd0, 3'd6, 3'd6, 3'd6, 3'd7},
    '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7}
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ilr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ilr_out_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  logic [2:0]  word_state = ST_START;
  logic        count_armed = 1'b1;
  logic [15:0] dec_seen = '0;
  logic [15:0] oct_seen = '0;
  logic [15:0] hex_seen = '0;

  ilr_out_t   expected_q [$];
  pin_t       pin_q [$];
  logic [7:0] word_q [$];

  stim_row_t dir_rows [25] = '{
    '{"+", 1'b1, 1'b1, '{1'b0, 1'b0, 16'd1, 16'd0, 16'd0, 1'b1}},
    '{8'h00, 1'b0, 1'b1, '{1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1}},
    '{"0", 1'b1, 1'b1, '{1'b1, 1'b0, 16'd0, 16'd1, 16'd0, 1'b1}},
    '{"x", 1'b1, 1'b1, '{1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1}},
    '{"0", 1'b0, 1'b0, '0},
    '{"x", 1'b0, 1'b0, '0},
    '{"1", 1'b0, 1'b0, '0},
    '{"F", 1'b0, 1'b0, '0},
    '{"#", 1'b0, 1'b0, '0},
    '{"-", 1'b0, 1'b0, '0},
    '{"4", 1'b0, 1'b0, '0},
    '{"2", 1'b0, 1'b0, '0},
    '{"#", 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, '0},
    '{"1", 1'b0, 1'b0, '0},
    '{"7", 1'b0, 1'b0, '0},
    '{"#", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{"8", 1'b1, 1'b0, '0},
    '{"5", 1'b0, 1'b0, '0},
    '{"5", 1'b1, 1'b0, '0},
    '{"0", 1'b0, 1'b0, '0},
    '{"x", 1'b0, 1'b0, '0},
    '{"G", 1'b1, 1'b0, '0}
  };

  integer_literal_list_recognizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [2:0] classify_char(input logic [7:0] c);
    if (c == "+" || c == "-") return CL_SIGN;
    if (c == "0") return CL_ZERO;
    if (c == "x") return CL_X;
    if (c == "#") return CL_SEP;
    if (c >= "1" && c <= "7") return CL_OCTDIG;
    if (c == "8" || c == "9") return CL_DECDIG;
    if (c >= "A" && c <= "F") return CL_HEXDIG;
    return CL_OTHER;
  endfunction

  function automatic ilr_out_t recognize_char(input ilr_in_t item);
    ilr_out_t   res;
    logic [2:0] nxt;
    nxt = MOVE[word_state][classify_char(item.char_code)];
    word_state = nxt;
    if (count_armed) begin
      if (nxt == ST_LEAD || nxt == ST_DEC) begin
        dec_seen += (dec_seen != 16'hFFFF);
        count_armed = 1'b0;
      end
      if (nxt == ST_ZERO) oct_seen += (oct_seen != 16'hFFFF);
      if (nxt == ST_HEX_X) begin
        hex_seen += (hex_seen != 16'hFFFF);
        oct_seen -= (oct_seen != 16'd0);
      end
    end
    if (nxt == ST_START) count_armed = 1'b1;
    res.accepted = item.last_char &&
                   (nxt == ST_ZERO || nxt == ST_DEC || nxt == ST_OCT || nxt == ST_HEX);
    res.rejected = (nxt == ST_REJECT);
    res.decimal_count = dec_seen;
    res.octal_count = oct_seen;
    res.hex_count = hex_seen;
    res.word_done = item.last_char;
    if (item.last_char) begin
      word_state = ST_START;
      count_armed = 1'b1;
      dec_seen = '0;
      oct_seen = '0;
      hex_seen = '0;
    end
    return res;
  endfunction

  function automatic logic [7:0] hex_digit();
    int idx;
    idx = $urandom_range(0, 15);
    return (idx < 10) ? 8'("0" + idx) : 8'("A" + idx - 10);
  endfunction

  // Mostly well-formed lists of literals; about one word in two is damaged or pure noise.
  function automatic void build_word();
    string symbols;
    int    n_lits;
    int    len;
    symbols = "+-0x#79AFGa";
    word_q.delete();
    n_lits = $urandom_range(1, 6);
    for (int i = 0; i < n_lits; i++) begin
      if (i > 0) word_q.push_back("#");
      len = $urandom_range(1, 4);
      case ($urandom_range(0, 2))
        0: begin
          if ($urandom_range(0, 1)) word_q.push_back($urandom_range(0, 1) ? "+" : "-");
          else word_q.push_back(8'("0" + $urandom_range(1, 9)));
          for (int k = 0; k < len; k++) word_q.push_back(8'("0" + $urandom_range(0, 9)));
        end
        1: begin
          word_q.push_back("0");
          for (int k = 1; k < len; k++) word_q.push_back(8'("0" + $urandom_range(0, 7)));
        end
        default: begin
          word_q.push_back("0");
          word_q.push_back("x");
          for (int k = 0; k < len; k++) word_q.push_back(hex_digit());
        end
      endcase
    end
    case ($urandom_range(0, 7))
      0: word_q[$urandom_range(0, word_q.size() - 1)] = 8'($urandom_range(0, 255));
      1: word_q.push_back("#");
      2: begin
        word_q.delete();
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 1)) word_q.push_back(8'($urandom_range(0, 255)));
          else word_q.push_back(symbols[$urandom_range(0, symbols.len() - 1)]);
        end
      end
      3: if (word_q.size() > 1) void'(word_q.pop_back());
      default: ;
    endcase
  endfunction

  task automatic send_item(input ilr_in_t item, input bit pinned, input ilr_out_t want);
    pin_t pin;
    pin.pinned = pinned;
    pin.want = want;
    pin_q.push_back(pin);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    ilr_out_t want;
    pin_t     pin;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result item arrived with none expected");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("accepted", want.accepted, out_data.accepted);
          compare_field("rejected", want.rejected, out_data.rejected);
          compare_field("decimal_count", want.decimal_count, out_data.decimal_count);
          compare_field("octal_count", want.octal_count, out_data.octal_count);
          compare_field("hex_count", want.hex_count, out_data.hex_count);
          compare_field("word_done", want.word_done, out_data.word_done);
        end
      end
      if (in_valid && !in_stall) begin
        pin = pin_q.pop_front();
        want = recognize_char(in_data);
        expected_q.push_back(pin.pinned ? pin.want : want);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("integer_literal_list_recognizer_tb: FAIL");
      $finish;
    end
  end

  initial begin
    ilr_in_t item;
    int      sent;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[r]) begin
      item.char_code = dir_rows[r].ch;
      item.last_char = dir_rows[r].last;
      send_item(item, dir_rows[r].pinned, dir_rows[r].want);
    end
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        build_word();
        foreach (word_q[k]) begin
          item.char_code = word_q[k];
          item.last_char = (k == word_q.size() - 1);
          send_item(item, 1'b0, '0);
        end
        sent += word_q.size();
      end
    end
    in_valid <= 1'b0;
    while (expected_q.size() != 0 || pin_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("integer_literal_list_recognizer_tb: PASS");
    end else begin
      $display("integer_literal_list_recognizer_tb: FAIL");
    end
    $finish;
  end

endmodule
